/* src/sih_pkg.sv */
// ----------------------------------------------------------------------------
// sih_pkg
// Shared types, constants and the FNV-1a step for the string intern table.
// ----------------------------------------------------------------------------
package sih_pkg;

	localparam int unsigned DEF_TABLE_SLOTS = 1024;
	localparam int unsigned DEF_ARENA_BYTES = 65536;
	localparam int unsigned MAX_KEY_LEN     = 64;
	localparam int unsigned KEY_AW          = $clog2(MAX_KEY_LEN);
	localparam int unsigned LEN_W           = 7;
	localparam int unsigned CFG_W           = 11;
	localparam logic [CFG_W-1:0] LIMIT_RESET = CFG_W'(768);

	localparam logic [63:0] FNV_BASIS = 64'hCBF2_9CE4_8422_2325;

	// status codes
	localparam logic [2:0] ST_FOUND      = 3'd0;
	localparam logic [2:0] ST_INSERTED   = 3'd1;
	localparam logic [2:0] ST_EMPTY      = 3'd2;
	localparam logic [2:0] ST_TABLE_FULL = 3'd3;
	localparam logic [2:0] ST_ARENA_FULL = 3'd4;
	localparam logic [2:0] ST_TOO_LONG   = 3'd5;
	localparam logic [2:0] ST_CLEARED    = 3'd6;

	// one finished key (or a clear) handed from front to back
	typedef struct packed {
		logic             clear;
		logic             overflow;
		logic [LEN_W-1:0] len;
		logic [63:0]      hash;
	} job_t;

	typedef enum logic [3:0] {
		BS_IDLE,
		BS_PROBE,
		BS_CHECK,
		BS_CMP,
		BS_CMP_CHK,
		BS_COPY,
		BS_COPY_WR,
		BS_TERM,
		BS_WIPE
	} back_state_t;

	// (h ^ b) * prime, prime = 2^40 + 0x1B3, as shifts and adds
	function automatic logic [63:0] fnv_step(input logic [63:0] h, input logic [7:0] b);
		logic [63:0] x;
		begin
			x = h ^ {56'd0, b};
			return (x << 40) + x + (x << 1) + (x << 4) + (x << 5) + (x << 7) + (x << 8);
		end
	endfunction

endpackage

/* src/sih_front.sv */
// ----------------------------------------------------------------------------
// sih_front
// Takes key bytes, hashes them, buffers the key and queues finished keys.
// ----------------------------------------------------------------------------
module sih_front (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      accept,
	input  logic                      command,
	input  logic [7:0]                key_byte,
	input  logic                      key_last,
	output logic                      push,
	output sih_pkg::job_t             job,
	input  logic [sih_pkg::KEY_AW-1:0] kb_raddr,
	output logic [7:0]                kb_rdata
);
	import sih_pkg::*;

	logic [7:0]       key_mem [MAX_KEY_LEN];
	logic [LEN_W-1:0] seen_q;
	logic [63:0]      hash_q;
	logic             ovf_q;
	logic             ended_q;

	logic [63:0] hash_nxt;
	logic        live;
	logic        take;
	logic        ovf_now;

	// classify the byte
	assign hash_nxt = fnv_step(hash_q, key_byte);
	assign live     = !ended_q && (key_byte != 8'd0);
	assign take     = live && (seen_q < LEN_W'(MAX_KEY_LEN));
	assign ovf_now  = live && !take;

	assign push          = accept && (command || key_last);
	assign job.clear     = command;
	assign job.overflow  = ovf_q || ovf_now;
	assign job.len       = take ? seen_q + LEN_W'(1) : seen_q;
	assign job.hash      = take ? hash_nxt : hash_q;

	// key assembly state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q  <= '0;
			hash_q  <= FNV_BASIS;
			ovf_q   <= 1'b0;
			ended_q <= 1'b0;
		end else if (accept) begin
			if (command || key_last) begin
				seen_q  <= '0;
				hash_q  <= FNV_BASIS;
				ovf_q   <= 1'b0;
				ended_q <= 1'b0;
			end else begin
				if (take) begin
					seen_q <= seen_q + LEN_W'(1);
					hash_q <= hash_nxt;
				end
				if (ovf_now) ovf_q <= 1'b1;
				if (!ended_q && key_byte == 8'd0) ended_q <= 1'b1;
			end
		end
	end

	// key buffer, one write and one registered read
	always_ff @(posedge clk) begin
		if (accept && !command && take) key_mem[seen_q[KEY_AW-1:0]] <= key_byte;
		kb_rdata <= key_mem[kb_raddr];
	end

endmodule

/* src/sih_fifo.sv */
// ----------------------------------------------------------------------------
// sih_fifo
// Two-entry job queue between front and back.
// ----------------------------------------------------------------------------
module sih_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          enq,
	input  sih_pkg::job_t enq_job,
	output logic          enq_ready,
	input  logic          deq,
	output sih_pkg::job_t deq_job,
	output logic          deq_valid
);
	import sih_pkg::*;

	job_t       mem_q [2];
	logic       wp_q;
	logic       rp_q;
	logic [1:0] cnt_q;

	assign enq_ready = (cnt_q != 2'd2);
	assign deq_valid = (cnt_q != 2'd0);
	assign deq_job   = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (enq && enq_ready) mem_q[wp_q] <= enq_job;
	end

	// pointers and fill
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (enq && enq_ready) wp_q <= !wp_q;
			if (deq && deq_valid) rp_q <= !rp_q;
			cnt_q <= cnt_q + 2'((enq && enq_ready) ? 1 : 0) - 2'((deq && deq_valid) ? 1 : 0);
		end
	end

endmodule

/* src/sih_back.sv */
// ----------------------------------------------------------------------------
// sih_back
// Probe walk, byte compare, arena copy and insert; owns table and arena.
// ----------------------------------------------------------------------------
module sih_back #(
	parameter int unsigned TABLE_SLOTS = sih_pkg::DEF_TABLE_SLOTS,
	parameter int unsigned ARENA_BYTES = sih_pkg::DEF_ARENA_BYTES
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       deq_valid,
	input  sih_pkg::job_t              deq_job,
	output logic                       deq,
	output logic                       busy,
	input  logic [sih_pkg::CFG_W-1:0]  entry_limit,
	output logic [sih_pkg::KEY_AW-1:0] kb_raddr,
	input  logic [7:0]                 kb_rdata,
	output logic                       done,
	output logic [15:0]                handle,
	output logic [sih_pkg::LEN_W-1:0]  key_length,
	output logic [63:0]                key_hash,
	output logic [2:0]                 status
);
	import sih_pkg::*;

	localparam int unsigned SW = $clog2(TABLE_SLOTS);
	localparam int unsigned CW = $clog2(TABLE_SLOTS + 1);
	localparam int unsigned AW = $clog2(ARENA_BYTES);
	localparam int unsigned FW = $clog2(ARENA_BYTES + 1);
	localparam int unsigned LW = (CW > CFG_W) ? CW : CFG_W;

	back_state_t state_q, state_d;
	job_t        job_q, job_d, e_job;
	logic [SW-1:0]    pos_q, pos_d, n_q, n_d;
	logic [SW-1:0]    wipe_q, wipe_d;
	logic [LEN_W-1:0] i_q, i_d;
	logic [CW-1:0]    cnt_q, cnt_d;
	logic [FW-1:0]    fill_q, fill_d;

	// slot table and arena memories
	logic             sl_valid_mem [TABLE_SLOTS];
	logic [63:0]      sl_hash_mem [TABLE_SLOTS];
	logic [AW-1:0]    sl_off_mem  [TABLE_SLOTS];
	logic [LEN_W-1:0] sl_len_mem  [TABLE_SLOTS];
	logic [7:0]       arena_mem   [ARENA_BYTES];
	logic             sl_valid_rd;
	logic [63:0]      sl_hash_rd;
	logic [AW-1:0]    sl_off_rd;
	logic [LEN_W-1:0] sl_len_rd;
	logic [7:0]       ar_rdata;

	logic          wipe_we, slot_we, ar_we, emit;
	logic [2:0]    emit_st;
	logic [15:0]   emit_hdl;
	logic [AW-1:0] ar_waddr, ar_raddr;
	logic [7:0]    ar_wdata;
	logic          room_bad;

	assign busy  = (state_q != BS_IDLE);
	assign e_job = (state_q == BS_IDLE) ? deq_job : job_q;
	assign room_bad = ((FW+1)'(fill_q) + (FW+1)'(job_q.len) + (FW+1)'(1))
		> (FW+1)'(ARENA_BYTES);

	// next state and datapath control
	always_comb begin
		state_d  = state_q;
		job_d    = job_q;
		pos_d    = pos_q;
		n_d      = n_q;
		i_d      = i_q;
		cnt_d    = cnt_q;
		fill_d   = fill_q;
		wipe_d   = wipe_q;
		deq      = 1'b0;
		emit     = 1'b0;
		emit_st  = ST_FOUND;
		emit_hdl = '0;
		wipe_we  = 1'b0;
		slot_we  = 1'b0;
		ar_we    = 1'b0;
		ar_waddr = fill_q[AW-1:0] + AW'(i_q);
		ar_wdata = kb_rdata;
		ar_raddr = sl_off_rd + AW'(i_q);
		kb_raddr = i_q[KEY_AW-1:0];
		unique case (state_q)
			BS_IDLE: begin
				if (deq_valid) begin
					deq   = 1'b1;
					job_d = deq_job;
					priority if (deq_job.clear) begin
						cnt_d   = '0;
						fill_d  = '0;
						wipe_d  = '0;
						emit    = 1'b1;
						emit_st = ST_CLEARED;
						state_d = BS_WIPE;
					end else if (deq_job.overflow) begin
						emit    = 1'b1;
						emit_st = ST_TOO_LONG;
					end else if (deq_job.len == '0) begin
						emit    = 1'b1;
						emit_st = ST_EMPTY;
					end else begin
						pos_d   = deq_job.hash[SW-1:0];
						n_d     = '0;
						state_d = BS_PROBE;
					end
				end
			end
			BS_PROBE: state_d = BS_CHECK;
			BS_CHECK: begin
				if (!sl_valid_rd) begin
					priority if (LW'(cnt_q) >= LW'(entry_limit)) begin
						emit    = 1'b1;
						emit_st = ST_TABLE_FULL;
						state_d = BS_IDLE;
					end else if (room_bad) begin
						emit    = 1'b1;
						emit_st = ST_ARENA_FULL;
						state_d = BS_IDLE;
					end else begin
						i_d     = '0;
						state_d = BS_COPY;
					end
				end else if (sl_hash_rd == job_q.hash && sl_len_rd == job_q.len) begin
					i_d     = '0;
					state_d = BS_CMP;
				end else if (&n_q) begin
					emit    = 1'b1;
					emit_st = ST_TABLE_FULL;
					state_d = BS_IDLE;
				end else begin
					n_d     = n_q + SW'(1);
					pos_d   = pos_q + SW'(1);
					state_d = BS_PROBE;
				end
			end
			BS_CMP: state_d = BS_CMP_CHK;
			BS_CMP_CHK: begin
				if (ar_rdata != kb_rdata) begin
					if (&n_q) begin
						emit    = 1'b1;
						emit_st = ST_TABLE_FULL;
						state_d = BS_IDLE;
					end else begin
						n_d     = n_q + SW'(1);
						pos_d   = pos_q + SW'(1);
						state_d = BS_PROBE;
					end
				end else if (i_q == job_q.len - LEN_W'(1)) begin
					emit     = 1'b1;
					emit_st  = ST_FOUND;
					emit_hdl = 16'(sl_off_rd);
					state_d  = BS_IDLE;
				end else begin
					i_d     = i_q + LEN_W'(1);
					state_d = BS_CMP;
				end
			end
			BS_COPY: state_d = BS_COPY_WR;
			BS_COPY_WR: begin
				ar_we = 1'b1;
				if (i_q == job_q.len - LEN_W'(1)) begin
					state_d = BS_TERM;
				end else begin
					i_d     = i_q + LEN_W'(1);
					state_d = BS_COPY;
				end
			end
			BS_TERM: begin
				ar_we    = 1'b1;
				ar_waddr = fill_q[AW-1:0] + AW'(job_q.len);
				ar_wdata = 8'd0;
				slot_we  = 1'b1;
				cnt_d    = cnt_q + CW'(1);
				fill_d   = fill_q + FW'(job_q.len) + FW'(1);
				emit     = 1'b1;
				emit_st  = ST_INSERTED;
				emit_hdl = 16'(fill_q);
				state_d  = BS_IDLE;
			end
			// one slot valid bit cleared per cycle
			BS_WIPE: begin
				wipe_we = 1'b1;
				wipe_d  = wipe_q + SW'(1);
				if (&wipe_q) state_d = BS_IDLE;
			end
			default: state_d = BS_IDLE;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BS_WIPE;
			wipe_q  <= '0;
			cnt_q   <= '0;
			fill_q  <= '0;
			done    <= 1'b0;
		end else begin
			state_q <= state_d;
			wipe_q  <= wipe_d;
			cnt_q   <= cnt_d;
			fill_q  <= fill_d;
			done    <= emit;
		end
	end

	// walk registers and result beat
	always_ff @(posedge clk) begin
		job_q <= job_d;
		pos_q <= pos_d;
		n_q   <= n_d;
		i_q   <= i_d;
		if (emit) begin
			status     <= emit_st;
			handle     <= emit_hdl;
			key_length <= e_job.clear ? '0 : e_job.len;
			key_hash   <= e_job.clear ? '0 : e_job.hash;
		end
	end

	// slot table, read at the current probe slot
	always_ff @(posedge clk) begin
		if (wipe_we) sl_valid_mem[wipe_q] <= 1'b0;
		else if (slot_we) sl_valid_mem[pos_q] <= 1'b1;
		if (slot_we) begin
			sl_hash_mem[pos_q] <= job_q.hash;
			sl_off_mem[pos_q]  <= fill_q[AW-1:0];
			sl_len_mem[pos_q]  <= job_q.len;
		end
		sl_valid_rd <= sl_valid_mem[pos_q];
		sl_hash_rd  <= sl_hash_mem[pos_q];
		sl_off_rd   <= sl_off_mem[pos_q];
		sl_len_rd   <= sl_len_mem[pos_q];
	end

	// byte arena
	always_ff @(posedge clk) begin
		if (ar_we) arena_mem[ar_waddr] <= ar_wdata;
		ar_rdata <= arena_mem[ar_raddr];
	end

	a_check_after_probe: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == BS_CHECK |-> $past(state_q) == BS_PROBE)
		else $error("slot check without a preceding read");

	a_insert_counts: assert property (@(posedge clk) disable iff (!arst_n)
		done && status == ST_INSERTED |-> cnt_q == $past(cnt_q) + CW'(1))
		else $error("insert reported without entry count step");

	a_clear_empties: assert property (@(posedge clk) disable iff (!arst_n)
		done && status == ST_CLEARED |-> cnt_q == '0 && fill_q == '0 && state_q == BS_WIPE)
		else $error("clear reported without emptying the table");

endmodule

/* src/string_intern_hash_table_core.sv */
// ----------------------------------------------------------------------------
// string_intern_hash_table_core
// FNV-1a string interning table with linear probing and a byte arena.
// ----------------------------------------------------------------------------
// Input: one beat per key byte (command 0) or a clear (command 1), taken
// when start is high and busy is low. A beat with key_last or a clear makes
// one result; other beats make none.
// Result: handle, key_length, key_hash and status are valid for the single
// cycle in which done is high; the receiver has no stall.
// A last byte's job is dispatched from the job queue, then each probed slot
// is read and checked, each byte is compared on a hash match, each key byte
// is copied on an insert before the terminator, and done comes from the
// result register. Empty and overlong keys and clears are reported at
// dispatch. A clear then keeps busy high while the slot valid bits are
// wiped. busy stays high until the result is out, so one key is worked on
// at a time; the walk over the slot table and arena sets that.
// Configuration: cfg_data sets entry_limit on a cfg_valid beat; cfg_ready
// is always high. Write only while the block is idle.
// Reset: arena empty, entry_limit 768, no key in progress; busy is high
// after reset while the slot table is wiped.
// ----------------------------------------------------------------------------
module string_intern_hash_table_core #(
	parameter int unsigned TABLE_SLOTS = sih_pkg::DEF_TABLE_SLOTS,
	parameter int unsigned ARENA_BYTES = sih_pkg::DEF_ARENA_BYTES
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  logic                      command,
	input  logic [7:0]                key_byte,
	input  logic                      key_last,
	output logic                      done,
	output logic [15:0]               handle,
	output logic [sih_pkg::LEN_W-1:0] key_length,
	output logic [63:0]               key_hash,
	output logic [2:0]                status,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [sih_pkg::CFG_W-1:0] cfg_data
);
	import sih_pkg::*;

	logic              accept, push, enq_ready, deq, deq_valid, back_busy;
	job_t              job, deq_job;
	logic [KEY_AW-1:0] kb_raddr;
	logic [7:0]        kb_rdata;
	logic [CFG_W-1:0]  limit_q;

	assign busy      = back_busy || deq_valid || !enq_ready;
	assign accept    = start && !busy;
	assign cfg_ready = 1'b1;

	// entry limit register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) limit_q <= LIMIT_RESET;
		else if (cfg_valid && cfg_ready) limit_q <= cfg_data;
	end

	sih_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.command  (command),
		.key_byte (key_byte),
		.key_last (key_last),
		.push     (push),
		.job      (job),
		.kb_raddr (kb_raddr),
		.kb_rdata (kb_rdata)
	);

	sih_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.enq       (push),
		.enq_job   (job),
		.enq_ready (enq_ready),
		.deq       (deq),
		.deq_job   (deq_job),
		.deq_valid (deq_valid)
	);

	sih_back #(
		.TABLE_SLOTS (TABLE_SLOTS),
		.ARENA_BYTES (ARENA_BYTES)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.deq_valid   (deq_valid),
		.deq_job     (deq_job),
		.deq         (deq),
		.busy        (back_busy),
		.entry_limit (limit_q),
		.kb_raddr    (kb_raddr),
		.kb_rdata    (kb_rdata),
		.done        (done),
		.handle      (handle),
		.key_length  (key_length),
		.key_hash    (key_hash),
		.status      (status)
	);

endmodule
